// ----- hdl/ecnq_pkg.sv -----
package ecnq_pkg;

	localparam int HANDLE_W = 16;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 1;
	localparam int STATUS_W = 3;

	localparam logic [CFG_W-1:0] THR_RESET = 9'd20;
	localparam logic [CFG_W-1:0] MAX_RESET = 9'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARK_THRESHOLD = 1'd0,
		REG_MAX_OCCUPANCY  = 1'd1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SEND   = 3'd0,
		ST_QUEUED = 3'd1,
		ST_DROP   = 3'd2,
		ST_DEQ    = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef enum logic {
		FN_ENQ = 1'b0,
		FN_DEQ = 1'b1
	} func_t;

	// memory port strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// per-request outcome from the controller
	typedef struct packed {
		status_t status;
		logic    ecn;
		logic    ovf;
	} dec_t;

endpackage

// ----- hdl/ecnq_if.sv -----
interface ecnq_req_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [ecnq_pkg::HANDLE_W-1:0] handle;
	logic                          is_mgmt;
	logic                          force_queue;

	modport source (output valid, func, handle, is_mgmt, force_queue, input ready);
	modport sink (input valid, func, handle, is_mgmt, force_queue, output ready);
endinterface

interface ecnq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ecnq_pkg::STATUS_W-1:0] status;
	logic                          ecn_mark;
	logic [ecnq_pkg::HANDLE_W-1:0] out_handle;
	logic                          overflow;

	modport source (output valid, status, ecn_mark, out_handle, overflow, input ready);
	modport sink (input valid, status, ecn_mark, out_handle, overflow, output ready);
endinterface

interface ecnq_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ecnq_pkg::CFG_IDX_W-1:0] idx;
	logic [ecnq_pkg::CFG_W-1:0]     wdata;

	modport source (output valid, idx, wdata, input ready);
	modport sink (input valid, idx, wdata, output ready);
endinterface

// ----- hdl/ecnq_store.sv -----
module ecnq_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 16
) (
	input  logic               clk,
	input  ecnq_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]      waddr,
	input  logic [DW-1:0]      wdata,
	input  logic [AW-1:0]      raddr,
	output logic [DW-1:0]      rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/ecnq_ctrl.sv -----
module ecnq_ctrl #(
	parameter int QUEUE_DEPTH = 256,
	parameter int AW          = 8,
	parameter int OW          = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          func,
	input  logic                          is_mgmt,
	input  logic                          force_queue,
	input  logic [ecnq_pkg::CFG_W-1:0]    thr,
	input  logic [ecnq_pkg::CFG_W-1:0]    max_occ,
	output ecnq_pkg::dec_t                dec,
	output ecnq_pkg::mem_ctl_t            mem_ctl,
	output logic [AW-1:0]                 waddr,
	output logic [AW-1:0]                 raddr
);

	localparam int CW = (OW > ecnq_pkg::CFG_W) ? OW : ecnq_pkg::CFG_W;
	localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
	localparam logic [OW-1:0] FULL_OCC = OW'(QUEUE_DEPTH);

	logic [AW-1:0] rptr_q, wptr_q;
	logic [OW-1:0] occ_q;
	logic [CW-1:0] occ_c, thr_c, max_c;
	logic          empty, full, mark, drop_thr, send, queued, deq_ok;

	assign occ_c = CW'(occ_q);
	assign thr_c = CW'(thr);
	assign max_c = CW'(max_occ);
	assign empty = (occ_q == '0);
	assign full  = (occ_q == FULL_OCC);

	// marking window takes priority; drop only outside it
	assign mark     = (occ_c >= thr_c) && (occ_c < max_c);
	assign drop_thr = !mark && (occ_c >= max_c) && !is_mgmt;
	assign send     = !drop_thr && !force_queue && empty;
	assign queued   = !drop_thr && !send && !full;
	assign deq_ok   = !empty;

	always_comb begin
		dec = '{status: ecnq_pkg::ST_EMPTY, ecn: 1'b0, ovf: 1'b0};
		if (func == ecnq_pkg::FN_DEQ) begin
			dec.status = deq_ok ? ecnq_pkg::ST_DEQ : ecnq_pkg::ST_EMPTY;
		end else begin
			priority if (drop_thr) begin
				dec.status = ecnq_pkg::ST_DROP;
			end else if (send) begin
				dec.status = ecnq_pkg::ST_SEND;
				dec.ecn    = mark;
			end else if (full) begin
				dec.status = ecnq_pkg::ST_DROP;
				dec.ovf    = 1'b1;
			end else begin
				dec.status = ecnq_pkg::ST_QUEUED;
				dec.ecn    = mark;
			end
		end
	end

	assign mem_ctl.wr_en = fire && (func == ecnq_pkg::FN_ENQ) && queued;
	assign mem_ctl.rd_en = fire && (func == ecnq_pkg::FN_DEQ) && deq_ok;
	assign waddr = wptr_q;
	assign raddr = rptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q <= '0;
			wptr_q <= '0;
			occ_q  <= '0;
		end else begin
			if (mem_ctl.wr_en) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + AW'(1);
				occ_q  <= occ_q + OW'(1);
			end else if (mem_ctl.rd_en) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + AW'(1);
				occ_q  <= occ_q - OW'(1);
			end
		end
	end

endmodule

// ----- hdl/ecn_marking_drop_queue_unit.sv -----
// Response: an accepted request's outcome is registered and is valid in the next cycle.
// Throughput: one request per cycle unless the response stalls; decision uses only occupancy
// and threshold registers; the handle memory read on dequeue lands in the same cycle's result.
// Reset (arst_n low): pointers and occupancy clear, thresholds return to 20 / 200,
// the output register empties; handle memory content is left as is.
module ecn_marking_drop_queue_unit #(
	parameter int QUEUE_DEPTH = 256,
	parameter int HANDLE_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	ecnq_req_if.sink   req,
	ecnq_rsp_if.source rsp,
	ecnq_cfg_if.sink   cfg
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	// stored handle width; handles wider than the port are limited to the port
	localparam int SW = (HANDLE_BITS < ecnq_pkg::HANDLE_W) ? HANDLE_BITS : ecnq_pkg::HANDLE_W;

	logic [ecnq_pkg::CFG_W-1:0] thr_q, max_q;
	logic                       fire;
	ecnq_pkg::dec_t             dec;
	ecnq_pkg::mem_ctl_t         mem_ctl;
	logic [AW-1:0]              waddr, raddr;
	logic [SW-1:0]              rdata;
	logic [SW-1:0]              hdl_in;

	logic                          vld_s1;
	ecnq_pkg::status_t             status_s1;
	logic                          ecn_s1, ovf_s1;
	logic [ecnq_pkg::HANDLE_W-1:0] hdl_s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ecnq_pkg::THR_RESET;
			max_q <= ecnq_pkg::MAX_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				ecnq_pkg::REG_MARK_THRESHOLD: thr_q <= cfg.wdata;
				ecnq_pkg::REG_MAX_OCCUPANCY:  max_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	assign req.ready = !vld_s1 || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign hdl_in    = req.handle[SW-1:0];

	ecnq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.AW          (AW),
		.OW          (OW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.func        (req.func),
		.is_mgmt     (req.is_mgmt),
		.force_queue (req.force_queue),
		.thr         (thr_q),
		.max_occ     (max_q),
		.dec         (dec),
		.mem_ctl     (mem_ctl),
		.waddr       (waddr),
		.raddr       (raddr)
	);

	ecnq_store #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW),
		.DW    (SW)
	) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (hdl_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1 <= dec.status;
			ecn_s1    <= dec.ecn;
			ovf_s1    <= dec.ovf;
			hdl_s1    <= (dec.status == ecnq_pkg::ST_SEND) ?
				ecnq_pkg::HANDLE_W'(hdl_in) : '0;
		end
	end

	assign rsp.valid      = vld_s1;
	assign rsp.status     = status_s1;
	assign rsp.ecn_mark   = ecn_s1;
	assign rsp.overflow   = ovf_s1;
	assign rsp.out_handle = (status_s1 == ecnq_pkg::ST_DEQ) ?
		ecnq_pkg::HANDLE_W'(rdata) : hdl_s1;

endmodule

// ----- hdl/ecnq_checker.sv -----
module ecnq_assertions (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [ecnq_pkg::STATUS_W-1:0] status,
	input logic                          ecn_mark,
	input logic [ecnq_pkg::HANDLE_W-1:0] out_handle,
	input logic                          overflow
);

	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ecnq_pkg::ST_SEND && status != ecnq_pkg::ST_DEQ
		|-> out_handle == '0)
		else $error("handle must be zero unless sent or dequeued");

	a_ovf_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |-> status == ecnq_pkg::ST_DROP && !ecn_mark)
		else $error("overflow only on unmarked drop");

	a_no_mark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ecnq_pkg::ST_DEQ || status == ecnq_pkg::ST_EMPTY ||
		status == ecnq_pkg::ST_DROP) |-> !ecn_mark)
		else $error("mark set on dequeue, empty or drop");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_handle))
		else $error("stalled response changed");

endmodule

bind ecn_marking_drop_queue_unit ecnq_assertions u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.ecn_mark   (rsp.ecn_mark),
	.out_handle (rsp.out_handle),
	.overflow   (rsp.overflow)
);

// ----- sim/ecnq_checker.sv -----
`timescale 1ns / 1ps

module ecnq_checker
	import ecnq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ecnq_req_if        req,
	ecnq_rsp_if        rsp,
	ecnq_cfg_if        cfg,
	output int         fail_count,
	output int         pending
);

	localparam int DEPTH = 256;

	typedef struct {
		status_t             status;
		logic                ecn;
		logic [HANDLE_W-1:0] hnd;
		logic                ovf;
	} pkt_outcome_t;

	pkt_outcome_t        outcome_q[$];
	logic [HANDLE_W-1:0] handle_store [DEPTH];
	logic [7:0]          rd_ptr;
	logic [7:0]          wr_ptr;
	logic [8:0]          occ;
	logic [CFG_W-1:0]    mark_thr;
	logic [CFG_W-1:0]    drop_level;

	task automatic decide_request(input func_t fn, input logic [HANDLE_W-1:0] h,
		input logic mgmt, input logic frc, output pkt_outcome_t o);
		logic mark;
		o = '{status: ST_EMPTY, ecn: 1'b0, hnd: '0, ovf: 1'b0};
		if (fn == FN_DEQ) begin
			if (occ != 0) begin
				o.status = ST_DEQ;
				o.hnd = handle_store[rd_ptr];
				rd_ptr = rd_ptr + 8'd1;
				occ = occ - 9'd1;
			end
		end else begin
			mark = (occ >= mark_thr) && (occ < drop_level);
			if (!mark && occ >= drop_level && !mgmt) begin
				o.status = ST_DROP;
			end else if (!frc && occ == 0) begin
				o.status = ST_SEND;
				o.ecn = mark;
				o.hnd = h;
			end else if (occ >= DEPTH) begin
				// physical store full, even management traffic is lost
				o.status = ST_DROP;
				o.ovf = 1'b1;
			end else begin
				handle_store[wr_ptr] = h;
				wr_ptr = wr_ptr + 8'd1;
				occ = occ + 9'd1;
				o.status = ST_QUEUED;
				o.ecn = mark;
			end
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		pkt_outcome_t exp_o;
		pkt_outcome_t new_o;
		if (!arst_n) begin
			rd_ptr = '0;
			wr_ptr = '0;
			occ = '0;
			mark_thr = THR_RESET;
			drop_level = MAX_RESET;
			outcome_q.delete();
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (outcome_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: response with no request pending: status %0d ecn %b handle %h ovf %b",
							$realtime, rsp.status, rsp.ecn_mark, rsp.out_handle, rsp.overflow);
				end else begin
					exp_o = outcome_q.pop_front();
					if (rsp.status !== exp_o.status || rsp.ecn_mark !== exp_o.ecn ||
						rsp.out_handle !== exp_o.hnd || rsp.overflow !== exp_o.ovf) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch: expected status %0d ecn %b handle %h ovf %b, got status %0d ecn %b handle %h ovf %b",
								$realtime, exp_o.status, exp_o.ecn, exp_o.hnd, exp_o.ovf,
								rsp.status, rsp.ecn_mark, rsp.out_handle, rsp.overflow);
					end
				end
			end
			if (req.valid && req.ready) begin
				decide_request(func_t'(req.func), req.handle, req.is_mgmt, req.force_queue, new_o);
				outcome_q.push_back(new_o);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.idx))
					REG_MARK_THRESHOLD: mark_thr = cfg.wdata;
					REG_MAX_OCCUPANCY:  drop_level = cfg.wdata;
					default: ;
				endcase
			end
			pending = outcome_q.size();
		end
	end

endmodule

// ----- sim/tb_ecn_marking_drop_queue_unit.sv -----
`timescale 1ns / 1ps

module tb_ecn_marking_drop_queue_unit;
	import ecnq_pkg::*;

	logic clk;
	logic arst_n;
	bit   steady;
	int   fail_count;
	int   pending;

	ecnq_req_if req ();
	ecnq_rsp_if rsp ();
	ecnq_cfg_if cfg ();

	ecn_marking_drop_queue_unit #(
		.QUEUE_DEPTH(256),
		.HANDLE_BITS(HANDLE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	ecnq_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		rsp.ready <= steady || ($urandom_range(99) >= 15);
	end

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_request(input func_t fn, input logic [HANDLE_W-1:0] h,
		input logic mgmt, input logic frc);
		while (!steady && $urandom_range(99) < 15) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.func <= fn;
		req.handle <= h;
		req.is_mgmt <= mgmt;
		req.force_queue <= frc;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.idx <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_levels(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] maxo);
		wait_drained();
		write_reg(REG_MARK_THRESHOLD, thr);
		write_reg(REG_MAX_OCCUPANCY, maxo);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] maxo,
		input int n, input int enq_pct, input int mgmt_pct, input int force_pct);
		func_t fn;
		set_levels(thr, maxo);
		for (int i = 0; i < n; i++) begin
			fn = ($urandom_range(99) < enq_pct) ? FN_ENQ : FN_DEQ;
			send_request(fn, HANDLE_W'($urandom), $urandom_range(99) < mgmt_pct,
				$urandom_range(99) < force_pct);
			if ($urandom_range(199) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		req.valid = 1'b0;
		req.func = FN_ENQ;
		req.handle = '0;
		req.is_mgmt = 1'b0;
		req.force_queue = 1'b0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.idx = REG_MARK_THRESHOLD;
		cfg.wdata = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset levels 20 / 200: empty dequeue, direct sends, plain queueing
		send_request(FN_DEQ, 16'hFFFF, 1'b1, 1'b1);
		send_request(FN_ENQ, 16'hFFFF, 1'b0, 1'b0);
		send_request(FN_ENQ, 16'h0000, 1'b1, 1'b0);
		send_request(FN_ENQ, 16'hA5A5, 1'b0, 1'b1);
		send_request(FN_ENQ, 16'h5A5A, 1'b1, 1'b0);
		send_request(FN_DEQ, 16'h0000, 1'b0, 1'b0);
		send_request(FN_DEQ, 16'h1234, 1'b0, 1'b1);
		send_request(FN_DEQ, 16'h0000, 1'b0, 1'b0);

		// narrow window: marking, threshold drop, management exemption
		set_levels(9'd1, 9'd3);
		send_request(FN_ENQ, 16'h0001, 1'b0, 1'b1);
		send_request(FN_ENQ, 16'h0002, 1'b0, 1'b0);
		send_request(FN_ENQ, 16'h0004, 1'b0, 1'b0);
		send_request(FN_ENQ, 16'h0008, 1'b0, 1'b1);
		send_request(FN_ENQ, 16'h8000, 1'b1, 1'b1);
		send_request(FN_ENQ, 16'h4000, 1'b0, 1'b0);
		send_request(FN_DEQ, 16'h0000, 1'b0, 1'b0);
		send_request(FN_DEQ, 16'h0000, 1'b0, 1'b0);
		send_request(FN_DEQ, 16'h0000, 1'b0, 1'b0);
		send_request(FN_DEQ, 16'h0000, 1'b0, 1'b0);
		send_request(FN_DEQ, 16'h0000, 1'b0, 1'b0);

		// zero threshold marks even a direct send
		set_levels(9'd0, 9'd5);
		send_request(FN_ENQ, 16'hC3C3, 1'b0, 1'b0);
		send_request(FN_ENQ, 16'h3C3C, 1'b1, 1'b0);

		run_phase(9'd20, 9'd200, 250, 60, 20, 50);
		// fill to the physical limit so management requests overflow
		run_phase(9'd0, 9'd256, 400, 92, 30, 50);
		run_phase(9'd511, 9'd511, 250, 80, 10, 40);
		run_phase(9'd0, 9'd0, 150, 50, 50, 50);
		run_phase(9'd300, 9'd100, 150, 60, 20, 50);
		run_phase(9'd256, 9'd256, 200, 15, 20, 50);
		for (int k = 0; k < 3; k++)
			run_phase(CFG_W'($urandom_range(40)), CFG_W'($urandom_range(40)), 120, 55, 25, 50);
		steady = 1'b1;
		run_phase(9'd256, 9'd256, 150, 70, 20, 50);
		steady = 1'b0;

		wait_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
